// ===== sv/rtrq_pkg.sv =====
`default_nettype none

package rtrq_pkg;

	// Field widths of the request and response payloads
	localparam int TASK_W = 4;
	localparam int CMD_W  = 2;

	// Default ring size
	localparam int DEFAULT_NUM_TASKS = 16;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [TASK_W-1:0] task_t;

	// Command codes
	localparam cmd_t CMD_ADD    = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_NEXT   = 2'd2;

	// Status codes
	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_IGNORED = 1'b1;

	// Strobes from the sequencer to the link table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic set_vld;
		logic clr_vld;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/rtrq_if.sv =====
`default_nettype none

// Request channel: command and task number
interface rtrq_req_if;
	logic                 valid;
	logic                 ready;
	rtrq_pkg::cmd_t       command;
	rtrq_pkg::task_t      task_id;

	modport source (output valid, output command, output task_id, input ready);
	modport sink   (input valid, input command, input task_id, output ready);
endinterface

// Response channel: chosen task, empty flag and status
interface rtrq_rsp_if;
	logic                 valid;
	logic                 ready;
	rtrq_pkg::task_t      chosen_task;
	logic                 queue_empty;
	logic                 status;

	modport source (output valid, output chosen_task, output queue_empty, output status,
		input ready);
	modport sink   (input valid, input chosen_task, input queue_empty, input status,
		output ready);
endinterface

`default_nettype wire

// ===== sv/rtrq_link_mem.sv =====
`default_nettype none

module rtrq_link_mem #(
	parameter int NUM_TASKS = rtrq_pkg::DEFAULT_NUM_TASKS,
	parameter int AW        = $clog2(NUM_TASKS)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire rtrq_pkg::mem_ctl_t ctl,
	input  wire  [AW-1:0]       rd_addr,
	input  wire  [AW-1:0]       wr_addr,
	input  wire  [AW-1:0]       wr_data,
	input  wire  [AW-1:0]       clr_addr,
	input  wire  [AW-1:0]       probe_addr,
	output logic [AW-1:0]       rd_data,
	output logic                rd_vld,
	output logic                probe_vld
);
	import rtrq_pkg::*;

	logic [AW-1:0]        link_mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] vld_q;
	logic [AW-1:0]        rd_data_q;
	logic                 rd_vld_q;

	// Write and read the successor links
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= link_mem[rd_addr];
		end
	end

	// Track which entries hold a queued task; reset empties the ring at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (ctl.set_vld) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.clr_vld) begin
				vld_q[clr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data   = rd_data_q;
	assign rd_vld    = rd_vld_q;
	assign probe_vld = vld_q[probe_addr];

endmodule

`default_nettype wire

// ===== sv/rtrq_seq.sv =====
`default_nettype none

module rtrq_seq #(
	parameter int NUM_TASKS = rtrq_pkg::DEFAULT_NUM_TASKS,
	parameter int AW        = $clog2(NUM_TASKS)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// request side
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire rtrq_pkg::cmd_t  in_command,
	input  wire rtrq_pkg::task_t in_task_id,
	// result side
	output logic                 res_valid,
	input  wire                  res_ready,
	output rtrq_pkg::task_t      res_chosen_task,
	output logic                 res_queue_empty,
	output logic                 res_status,
	// link table
	output rtrq_pkg::mem_ctl_t   ctl,
	output logic [AW-1:0]        rd_addr,
	output logic [AW-1:0]        wr_addr,
	output logic [AW-1:0]        wr_data,
	output logic [AW-1:0]        clr_addr,
	output logic [AW-1:0]        probe_addr,
	input  wire  [AW-1:0]        rd_data,
	input  wire                  rd_vld,
	input  wire                  probe_vld
);
	import rtrq_pkg::*;

	localparam int SW = $clog2(NUM_TASKS + 1);
	localparam int NW = $clog2(NUM_TASKS + 1);
	localparam int CW = (NW > TASK_W) ? NW : TASK_W;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_ADD_A   = 8'b0000_0010,
		ST_ADD_B   = 8'b0000_0100,
		ST_RM_SUCC = 8'b0000_1000,
		ST_RM_SCAN = 8'b0001_0000,
		ST_RM_WR   = 8'b0010_0000,
		ST_NEXT    = 8'b0100_0000,
		ST_RESP    = 8'b1000_0000
	} state_t;

	state_t        st_q;
	cmd_t          cmd_q;
	logic [AW-1:0] tid_q;
	task_t         chosen_q;
	logic          status_q;
	logic [AW-1:0] tail_q;
	logic          tail_vld_q;
	logic [AW-1:0] succ_q;
	logic [AW-1:0] pred_q;
	logic [SW-1:0] scan_q;
	logic          look_q;

	logic          accept;
	logic          in_rng;
	logic [AW-1:0] in_addr;
	logic          add_ok;
	logic          rm_ok;
	logic          add_first;
	state_t        st_accept;
	logic          hit;
	logic          scan_end;

	assign in_ready = (st_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_rng   = CW'(in_task_id) < CW'(NUM_TASKS);
	assign in_addr  = AW'(in_task_id);
	assign probe_addr = in_addr;
	assign add_ok   = in_rng && !probe_vld;
	assign rm_ok    = in_rng && probe_vld && tail_vld_q;

	// An add into an empty ring finishes in the accept cycle
	assign add_first = (in_command == CMD_ADD) && add_ok && !tail_vld_q;

	// Shared compare: does the entry read last cycle point at the task
	assign hit      = look_q && rd_vld && (rd_data == tid_q);
	assign scan_end = (scan_q == SW'(NUM_TASKS));

	// Pick the step that follows an accepted request
	always_comb begin
		st_accept = ST_RESP;
		case (in_command)
			CMD_ADD: begin
				if (add_ok && tail_vld_q) begin
					st_accept = ST_ADD_A;
				end
			end
			CMD_REMOVE: begin
				if (rm_ok) begin
					st_accept = ST_RM_SUCC;
				end
			end
			CMD_NEXT: begin
				if (tail_vld_q) begin
					st_accept = ST_NEXT;
				end
			end
			default: ;
		endcase
	end

	// Drive the link table port from the current step
	always_comb begin
		ctl      = '0;
		rd_addr  = tail_q;
		wr_addr  = tail_q;
		wr_data  = tid_q;
		clr_addr = tid_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_command)
						CMD_ADD: begin
							if (add_ok && tail_vld_q) begin
								ctl.rd_en = 1'b1;
							end else if (add_ok) begin
								ctl.wr_en   = 1'b1;
								ctl.set_vld = 1'b1;
								wr_addr     = in_addr;
								wr_data     = in_addr;
							end
						end
						CMD_REMOVE: begin
							if (rm_ok) begin
								ctl.rd_en = 1'b1;
								rd_addr   = in_addr;
							end
						end
						CMD_NEXT: begin
							ctl.rd_en = tail_vld_q;
						end
						default: ;
					endcase
				end
			end
			ST_ADD_A: begin
				ctl.wr_en = 1'b1;
			end
			ST_ADD_B: begin
				ctl.wr_en   = 1'b1;
				ctl.set_vld = 1'b1;
				wr_addr     = tid_q;
				wr_data     = succ_q;
			end
			ST_RM_SCAN: begin
				if (!hit && !scan_end) begin
					ctl.rd_en = 1'b1;
					rd_addr   = scan_q[AW-1:0];
				end
			end
			ST_RM_WR: begin
				ctl.wr_en   = 1'b1;
				ctl.clr_vld = 1'b1;
				wr_addr     = pred_q;
				wr_data     = succ_q;
			end
			ST_RM_SUCC, ST_NEXT, ST_RESP: ;
			default: ;
		endcase
	end

	// Advance the sequencer and update the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			tail_vld_q <= 1'b0;
			look_q     <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= in_command;
						tid_q    <= in_addr;
						chosen_q <= '0;
						status_q <= add_first ? STATUS_DONE : STATUS_IGNORED;
						st_q     <= st_accept;
						if (add_first) begin
							tail_q     <= in_addr;
							tail_vld_q <= 1'b1;
						end
					end
				end
				ST_ADD_A: begin
					succ_q <= rd_data;
					st_q   <= ST_ADD_B;
				end
				ST_ADD_B: begin
					tail_q   <= tid_q;
					status_q <= STATUS_DONE;
					st_q     <= ST_RESP;
				end
				ST_RM_SUCC: begin
					succ_q <= rd_data;
					scan_q <= '0;
					look_q <= 1'b0;
					st_q   <= ST_RM_SCAN;
				end
				ST_RM_SCAN: begin
					if (hit) begin
						pred_q <= scan_q[AW-1:0] - AW'(1);
						look_q <= 1'b0;
						st_q   <= ST_RM_WR;
					end else if (scan_end) begin
						look_q <= 1'b0;
						st_q   <= ST_RESP;
					end else begin
						scan_q <= scan_q + SW'(1);
						look_q <= 1'b1;
					end
				end
				ST_RM_WR: begin
					if (tid_q == tail_q) begin
						if (pred_q == tid_q) begin
							tail_vld_q <= 1'b0;
						end else begin
							tail_q <= pred_q;
						end
					end
					status_q <= STATUS_DONE;
					st_q     <= ST_RESP;
				end
				ST_NEXT: begin
					chosen_q <= TASK_W'(tail_q);
					tail_q   <= rd_data;
					status_q <= STATUS_DONE;
					st_q     <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid       = (st_q == ST_RESP);
	assign res_chosen_task = chosen_q;
	assign res_queue_empty = !tail_vld_q;
	assign res_status      = status_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while a previous one is in work");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RM_SCAN) |-> (scan_q <= SW'(NUM_TASKS)))
		else $error("predecessor scan ran past the link table");
	a_next_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (cmd_q == CMD_NEXT) && (res_status == STATUS_DONE))
		|-> (res_chosen_task == TASK_W'(0) || tail_vld_q))
		else $error("next succeeded but left the ring empty");
	a_add_sets_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ADD_B) |=> (tail_vld_q && tail_q == tid_q))
		else $error("add did not move the tail to the new task");
`endif

endmodule

`default_nettype wire

// ===== sv/ready_task_ring_queue.sv =====
`default_nettype none

// Channel  Dir  Payload                              Handshake
// req      in   command, task_id                     valid/ready, taken on both high
// rsp      out  chosen_task, queue_empty, status     valid/ready, taken on both high
//
// Add into an empty ring finishes on accept, else ST_ADD_A and ST_ADD_B link it
// behind the tail. Remove's predecessor search reads the single read port of the
// link table one entry a cycle. Ignored requests go straight to ST_RESP.
// Reset clears the per-task valid flags at once; no clearing pass is needed.
// A finished response waits in the output register; a full register stalls the
// sequencer before it returns to idle.

module ready_task_ring_queue #(
	parameter int NUM_TASKS = rtrq_pkg::DEFAULT_NUM_TASKS
) (
	input  wire        clk,
	input  wire        arst_n,
	rtrq_req_if.sink   req,
	rtrq_rsp_if.source rsp
);
	import rtrq_pkg::*;

	localparam int AW = $clog2(NUM_TASKS);

	mem_ctl_t      ctl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] wr_data;
	logic [AW-1:0] clr_addr;
	logic [AW-1:0] probe_addr;
	logic [AW-1:0] rd_data;
	logic          rd_vld;
	logic          probe_vld;

	logic          res_valid;
	logic          res_ready;
	task_t         res_chosen_task;
	logic          res_queue_empty;
	logic          res_status;

	logic          out_vld_q;
	task_t         out_chosen_q;
	logic          out_empty_q;
	logic          out_status_q;

	rtrq_link_mem #(
		.NUM_TASKS (NUM_TASKS),
		.AW        (AW)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.clr_addr   (clr_addr),
		.probe_addr (probe_addr),
		.rd_data    (rd_data),
		.rd_vld     (rd_vld),
		.probe_vld  (probe_vld)
	);

	rtrq_seq #(
		.NUM_TASKS (NUM_TASKS),
		.AW        (AW)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (req.valid),
		.in_ready        (req.ready),
		.in_command      (req.command),
		.in_task_id      (req.task_id),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res_chosen_task (res_chosen_task),
		.res_queue_empty (res_queue_empty),
		.res_status      (res_status),
		.ctl             (ctl),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.clr_addr        (clr_addr),
		.probe_addr      (probe_addr),
		.rd_data         (rd_data),
		.rd_vld          (rd_vld),
		.probe_vld       (probe_vld)
	);

	// Hold the response until the consumer takes it
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_chosen_q <= res_chosen_task;
			out_empty_q  <= res_queue_empty;
			out_status_q <= res_status;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.chosen_task = out_chosen_q;
	assign rsp.queue_empty = out_empty_q;
	assign rsp.status      = out_status_q;

endmodule

`default_nettype wire
